>>> hdl/pfld_pkg.sv
package pfld_pkg;

   localparam logic [2:0] KIND_SET    = 3'd0;
   localparam logic [2:0] KIND_CLEAR  = 3'd1;
   localparam logic [2:0] KIND_LINE   = 3'd2;
   localparam logic [2:0] KIND_SCROLL = 3'd3;
   localparam logic [2:0] KIND_ROTATE = 3'd4;
   localparam logic [2:0] KIND_WIPE   = 3'd5;
   localparam logic [2:0] KIND_READ   = 3'd6;

   localparam logic [7:0] TOP_MASK = 8'h80;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic pt_rd;
      logic pt_wr;
      logic line_adv;
      logic sh_rd;
      logic sh_wr;
      logic sh_last;
      logic scroll_load;
      logic rd_rd;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       clr_last;
      logic       pt_on;
      logic       line_last;
      logic       col_last;
      logic       page_last;
   } status_type;

endpackage

>>> hdl/pfld_ctrl.sv
module pfld_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2:0]          req_kind,
   input  pfld_pkg::status_type status,
   output pfld_pkg::cmd_type    cmd,
   output logic                busy
);
   import pfld_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_INIT   = 9'b000000010,
      ST_CLEAR  = 9'b000000100,
      ST_PT_RD  = 9'b000001000,
      ST_PT_WR  = 9'b000010000,
      ST_PT_NXT = 9'b000100000,
      ST_SH_RD  = 9'b001000000,
      ST_SH_WR  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      sh_last_phase_ff, sh_last_phase_in;
   logic      rd_phase_ff, rd_phase_in;

   always_comb begin
      state_in         = state_ff;
      sh_last_phase_in = sh_last_phase_ff;
      rd_phase_in      = rd_phase_ff;
      cmd              = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_kind) inside
                  KIND_SET, KIND_CLEAR, KIND_LINE: state_in = ST_PT_RD;
                  KIND_SCROLL, KIND_ROTATE: begin
                     state_in         = ST_SH_RD;
                     sh_last_phase_in = 1'b0;
                  end
                  KIND_WIPE: state_in = ST_CLEAR;
                  KIND_READ: begin
                     state_in    = ST_FINISH;
                     rd_phase_in = 1'b1;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_INIT: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_FINISH;
         end
         ST_PT_RD: begin
            cmd.pt_rd = status.pt_on;
            state_in  = status.pt_on ? ST_PT_WR : ST_PT_NXT;
         end
         ST_PT_WR: begin
            cmd.pt_wr = 1'b1;
            state_in  = ST_PT_NXT;
         end
         ST_PT_NXT: begin
            if (status.kind == KIND_LINE && !status.line_last) begin
               cmd.line_adv = 1'b1;
               state_in     = ST_PT_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SH_RD: begin
            if (sh_last_phase_ff) begin
               cmd.sh_last      = 1'b1;
               sh_last_phase_in = 1'b0;
               if (status.page_last) begin
                  if (status.kind == KIND_SCROLL) begin
                     cmd.scroll_load = 1'b1;
                     state_in        = ST_PT_RD;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end else begin
               cmd.sh_rd = 1'b1;
               state_in  = ST_SH_WR;
            end
         end
         ST_SH_WR: begin
            cmd.sh_wr        = 1'b1;
            sh_last_phase_in = status.col_last;
            state_in         = ST_SH_RD;
         end
         ST_FINISH: begin
            if (rd_phase_ff) begin
               cmd.rd_rd   = 1'b1;
               rd_phase_in = 1'b0;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_INIT;
         sh_last_phase_ff <= 1'b0;
         rd_phase_ff      <= 1'b0;
      end else begin
         state_ff         <= state_in;
         sh_last_phase_ff <= sh_last_phase_in;
         rd_phase_ff      <= rd_phase_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> hdl/pfld_dpath.sv
module pfld_dpath #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfld_pkg::cmd_type    cmd,
   output pfld_pkg::status_type status,
   input  logic [2:0]           req_kind,
   input  logic [7:0]           req_start_x,
   input  logic [7:0]           req_start_y,
   input  logic [7:0]           req_end_x,
   input  logic [7:0]           req_end_y,
   input  logic [7:0]           req_sample_row,
   input  logic [2:0]           req_read_page,
   input  logic [7:0]           req_read_column,
   output logic                 rsp_strobe,
   output logic [7:0]           rsp_read_data,
   output logic                 rsp_read_valid
);
   import pfld_pkg::*;

   localparam int DEPTH = PAGES * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int ROWS  = PAGES * 8;

   logic [7:0] frame_mem_ff [DEPTH];

   logic [2:0]  kind_ff;
   logic [7:0]  x_ff, y_ff, sample_ff, rcol_ff;
   logic [2:0]  rpage_ff;
   logic [7:0]  dmaj_ff, dmin_ff, cnt_ff;
   logic [8:0]  rem_ff;
   logic        xmaj_ff, xup_ff, yup_ff;
   logic [3:0]  sh_page_ff;
   logic [7:0]  sh_col_ff;
   logic [7:0]  first_ff;
   logic [11:0] clr_cnt_ff;
   logic [7:0]  rdata_ff;
   logic        rsp_strobe_ff, rsp_valid_ff;
   logic [7:0]  rsp_data_ff;

   logic [7:0]  dx, dy;
   logic [8:0]  rem_sum, rem_next;
   logic        carry;
   logic        pt_on, rd_ok;
   logic [4:0]  pt_page;
   logic [11:0] pt_lin, sh_lin, sh_prev_lin, sh_end_lin, rd_lin;
   logic [7:0]  mask, wdata;
   logic        we, re;
   logic [AW-1:0] waddr, raddr;

   assign dx = (req_end_x >= req_start_x) ? req_end_x - req_start_x : req_start_x - req_end_x;
   assign dy = (req_end_y >= req_start_y) ? req_end_y - req_start_y : req_start_y - req_end_y;

   assign rem_sum  = rem_ff + {1'b0, dmin_ff};
   assign carry    = (rem_sum >= {1'b0, dmaj_ff});
   assign rem_next = carry ? rem_sum - {1'b0, dmaj_ff} : rem_sum;

   assign pt_on   = ({1'b0, x_ff} < 9'(COLUMNS)) && ({1'b0, y_ff} < 9'(ROWS));
   assign rd_ok   = ({1'b0, rpage_ff} < 4'(PAGES)) && ({1'b0, rcol_ff} < 9'(COLUMNS));
   assign pt_page = 5'(PAGES - 1) - y_ff[7:3];
   assign pt_lin  = 12'(pt_page) * 12'(COLUMNS) + 12'(x_ff);
   assign sh_lin      = 12'(sh_page_ff) * 12'(COLUMNS) + 12'(sh_col_ff);
   assign sh_prev_lin = sh_lin - 12'd1;
   assign sh_end_lin  = 12'(sh_page_ff) * 12'(COLUMNS) + 12'(COLUMNS - 1);
   assign rd_lin  = 12'(rpage_ff) * 12'(COLUMNS) + 12'(rcol_ff);
   assign mask    = TOP_MASK >> y_ff[2:0];

   always_comb begin
      we    = 1'b0;
      waddr = clr_cnt_ff[AW-1:0];
      wdata = 8'd0;
      if (cmd.clr_step) begin
         we = 1'b1;
      end else if (cmd.pt_wr) begin
         we    = 1'b1;
         waddr = pt_lin[AW-1:0];
         wdata = (kind_ff == KIND_CLEAR) ? (rdata_ff & ~mask) : (rdata_ff | mask);
      end else if (cmd.sh_wr) begin
         we    = (sh_col_ff != 8'd0);
         waddr = sh_prev_lin[AW-1:0];
         wdata = rdata_ff;
      end else if (cmd.sh_last) begin
         we    = 1'b1;
         waddr = sh_end_lin[AW-1:0];
         wdata = (kind_ff == KIND_ROTATE) ? first_ff : 8'd0;
      end
   end

   always_comb begin
      re    = 1'b0;
      raddr = pt_lin[AW-1:0];
      if (cmd.pt_rd) begin
         re = 1'b1;
      end else if (cmd.sh_rd) begin
         re    = 1'b1;
         raddr = sh_lin[AW-1:0];
      end else if (cmd.rd_rd) begin
         re    = rd_ok;
         raddr = rd_lin[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) frame_mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= frame_mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= 12'd0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.finish;
         if (cmd.load) clr_cnt_ff <= 12'd0;
         else if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + 12'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_kind;
         x_ff       <= req_start_x;
         y_ff       <= req_start_y;
         sample_ff  <= req_sample_row;
         rpage_ff   <= req_read_page;
         rcol_ff    <= req_read_column;
         xup_ff     <= (req_end_x >= req_start_x);
         yup_ff     <= (req_end_y >= req_start_y);
         xmaj_ff    <= (dx > dy);
         dmaj_ff    <= (dx > dy) ? dx : dy;
         dmin_ff    <= (dx > dy) ? dy : dx;
         cnt_ff     <= (dx > dy) ? dx : dy;
         rem_ff     <= 9'd0;
         sh_page_ff <= 4'd0;
         sh_col_ff  <= 8'd0;
      end
      if (cmd.line_adv) begin
         cnt_ff <= cnt_ff - 8'd1;
         rem_ff <= rem_next;
         if (xmaj_ff) begin
            x_ff <= xup_ff ? x_ff + 8'd1 : x_ff - 8'd1;
            if (carry) y_ff <= yup_ff ? y_ff + 8'd1 : y_ff - 8'd1;
         end else begin
            y_ff <= yup_ff ? y_ff + 8'd1 : y_ff - 8'd1;
            if (carry) x_ff <= xup_ff ? x_ff + 8'd1 : x_ff - 8'd1;
         end
      end
      if (cmd.sh_wr) begin
         if (sh_col_ff == 8'd0) first_ff <= rdata_ff;
         if (sh_col_ff != 8'(COLUMNS - 1)) sh_col_ff <= sh_col_ff + 8'd1;
      end
      if (cmd.sh_last) begin
         sh_col_ff  <= 8'd0;
         sh_page_ff <= sh_page_ff + 4'd1;
      end
      if (cmd.scroll_load) begin
         x_ff <= 8'(COLUMNS - 1);
         y_ff <= sample_ff;
      end
      if (cmd.finish) begin
         rsp_valid_ff <= (kind_ff == KIND_READ) && rd_ok;
         rsp_data_ff  <= ((kind_ff == KIND_READ) && rd_ok) ? rdata_ff : 8'd0;
      end
   end

   assign status.kind      = kind_ff;
   assign status.clr_last  = (clr_cnt_ff == 12'(DEPTH - 1));
   assign status.pt_on     = pt_on;
   assign status.line_last = (cnt_ff == 8'd0);
   assign status.col_last  = (sh_col_ff == 8'(COLUMNS - 1));
   assign status.page_last = (sh_page_ff == 4'(PAGES - 1));

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_read_valid = rsp_valid_ff;

endmodule

>>> hdl/page_framebuffer_line_draw_engine.sv
// monochrome page framebuffer with a drawing command engine
// input channel: a command is taken when start is high and busy is low;
//   req_kind picks set/clear pixel, line, scroll-in, rotate left, clear, read
// result channel: each command gives one item on rsp_read_data and
//   rsp_read_valid, shown for one cycle under rsp_strobe; the receiver
//   cannot stall, so no result is ever held back
// steps, shaped by the single write / single read port of the frame memory:
//   set/clear pixel reads the byte, then writes it masked; line does so per point;
//   scroll and rotate move each byte of a page, then fill its last column, and
//   scroll then sets the sampled pixel; clear zeroes each byte; read reads a byte
// the next command can be taken in the cycle the strobe is shown
// after reset a clearing pass writes zero to all PAGES*COLUMNS bytes, one a
//   cycle, with busy high; commands are taken once it ends
module page_framebuffer_line_draw_engine #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_start_x,
   input  logic [7:0] req_start_y,
   input  logic [7:0] req_end_x,
   input  logic [7:0] req_end_y,
   input  logic [7:0] req_sample_row,
   input  logic [2:0] req_read_page,
   input  logic [7:0] req_read_column,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_data,
   output logic       rsp_read_valid
);
   import pfld_pkg::*;

   cmd_type    cmd;
   status_type status;

   pfld_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   pfld_dpath #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_sample_row  (req_sample_row),
      .req_read_page   (req_read_page),
      .req_read_column (req_read_column),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_data   (rsp_read_data),
      .rsp_read_valid  (rsp_read_valid)
   );

endmodule
